// File: rtl/core/limited_range_histogram_top_assert.svh
// Assertion macros used by the checker file.
`ifndef LIMITED_RANGE_HISTOGRAM_TOP_ASSERT_SVH
`define LIMITED_RANGE_HISTOGRAM_TOP_ASSERT_SVH

// Check a property outside reset.
`define LRH_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property at every edge, reset included.
`define LRH_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/core/lrh_pkg.sv
package lrh_pkg;

  localparam int MaxItemsDef = 64;
  localparam int ValueWidth  = 16;
  localparam int BinWidth    = 7;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_UPDATE,
    ST_DUMP_RD,
    ST_DUMP_LD,
    ST_DUMP_OUT
  } state_t;

  typedef struct packed {
    logic in_ready;
    logic rd_lookup;
    logic wr_bin;
    logic rd_dump;
    logic load_out;
    logic out_valid;
  } ctrl_t;

  typedef struct packed {
    logic accept;
    logic bin_hit;
    logic last_in;
    logic last_pend;
    logic out_fire;
    logic final_out;
  } stat_t;

endpackage

// File: rtl/core/lrh_bin_ram.sv
module lrh_bin_ram
  import lrh_pkg::*;
#(
  parameter int Depth = MaxItemsDef,
  parameter int AddrWidth = $clog2(Depth)
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [AddrWidth-1:0] waddr,
  input  logic [BinWidth-1:0]  wdata,
  input  logic                 re,
  input  logic [AddrWidth-1:0] raddr,
  output logic [BinWidth-1:0]  rdata
);

  logic [BinWidth-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/core/lrh_seq.sv
module lrh_seq
  import lrh_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  stat_t stat,
  output ctrl_t ctrl
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (stat.accept) begin
          if (stat.bin_hit) begin
            state_next = ST_LOOKUP;
          end else if (stat.last_in) begin
            state_next = ST_DUMP_RD;
          end
        end
      end
      ST_LOOKUP: state_next = ST_UPDATE;
      ST_UPDATE: begin
        state_next = stat.last_pend ? ST_DUMP_RD : ST_IDLE;
      end
      ST_DUMP_RD: state_next = ST_DUMP_LD;
      ST_DUMP_LD: state_next = ST_DUMP_OUT;
      ST_DUMP_OUT: begin
        if (stat.out_fire) begin
          state_next = stat.final_out ? ST_IDLE : ST_DUMP_RD;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl = '0;
    case (state)
      ST_IDLE:     ctrl.in_ready  = 1'b1;
      ST_LOOKUP:   ctrl.rd_lookup = 1'b1;
      ST_UPDATE:   ctrl.wr_bin    = 1'b1;
      ST_DUMP_RD:  ctrl.rd_dump   = 1'b1;
      ST_DUMP_LD:  ctrl.load_out  = 1'b1;
      ST_DUMP_OUT: ctrl.out_valid = 1'b1;
      default:     ctrl = '0;
    endcase
  end

endmodule

// File: rtl/core/limited_range_histogram_top.sv
// Limited-range histogram.
// Input channel (in_valid/in_ready, value, last_item) takes one word per set
// element; last_item marks the final element. Output channel (out_valid/
// out_ready) returns, after the last word, one word per value 1..N with its
// count, where N is the number of words taken in the set (at most MaxItems).
// last_result flags the word for value N; overflow flags a set that carried
// more than MaxItems words (the extra words are dropped).
// Steps: a word whose value falls outside 1..MaxItems, or is dropped, is only
// accepted; a counted word is accepted, its bin read, then its bin written
// through the bin RAM and its one incrementer, and no new word is taken meanwhile.
// After the last word, each result is read, loaded and presented, and waits
// while the receiver holds out_ready low; in_ready stays low
// until the final result is taken, then all bins clear together.
// The result register holds its word while out_ready is low.
// Reset: synchronous rst empties the bins, item count and overflow flag and
// leaves the block ready for a new set.
module limited_range_histogram_top
  import lrh_pkg::*;
#(
  parameter int MaxItems = MaxItemsDef
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [ValueWidth-1:0] value,
  input  logic                  last_item,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [BinWidth-1:0]   count,
  output logic [BinWidth-1:0]   bin_value,
  output logic                  last_result,
  output logic                  overflow
);

  localparam int AW = $clog2(MaxItems);
  localparam int CW = $clog2(MaxItems + 1);

  ctrl_t ctrl;
  stat_t stat;

  logic [CW-1:0]       item_count;
  logic                overflow_seen;
  logic [AW-1:0]       val_idx;
  logic                last_r;
  logic [AW-1:0]       k;
  logic [MaxItems-1:0] valid;

  logic                accept;
  logic                out_fire;
  logic                dropped;
  logic                in_range;
  logic [AW-1:0]       raddr;
  logic [BinWidth-1:0] rd_data;
  logic [BinWidth-1:0] bin_cur;
  logic [BinWidth-1:0] inc_in;
  logic [BinWidth-1:0] inc_out;

  assign accept   = in_valid && ctrl.in_ready;
  assign out_fire = ctrl.out_valid && out_ready;
  assign dropped  = (item_count == CW'(MaxItems));
  assign in_range = (value != '0) && (value <= ValueWidth'(MaxItems));

  assign stat.accept    = accept;
  assign stat.bin_hit   = in_range && !dropped;
  assign stat.last_in   = last_item;
  assign stat.last_pend = last_r;
  assign stat.out_fire  = out_fire;
  assign stat.final_out = last_result;

  lrh_seq u_seq (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .ctrl (ctrl)
  );

  assign raddr = ctrl.rd_lookup ? val_idx : k;

  lrh_bin_ram #(
    .Depth (MaxItems)
  ) u_ram (
    .clk   (clk),
    .we    (ctrl.wr_bin),
    .waddr (val_idx),
    .wdata (inc_out),
    .re    (ctrl.rd_lookup || ctrl.rd_dump),
    .raddr (raddr),
    .rdata (rd_data)
  );

  // A bin not written since the last clear reads as zero.
  assign bin_cur = valid[ctrl.wr_bin ? val_idx : k] ? rd_data : '0;

  // Shared incrementer: bin count on update, bin number on dump.
  assign inc_in  = ctrl.wr_bin ? bin_cur : BinWidth'(k);
  assign inc_out = inc_in + BinWidth'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      item_count    <= '0;
      overflow_seen <= 1'b0;
      valid         <= '0;
      k             <= '0;
    end else begin
      if (accept) begin
        if (dropped) begin
          overflow_seen <= 1'b1;
        end else begin
          item_count <= item_count + CW'(1);
        end
      end
      if (ctrl.wr_bin) begin
        valid[val_idx] <= 1'b1;
      end
      if (out_fire) begin
        if (last_result) begin
          item_count    <= '0;
          overflow_seen <= 1'b0;
          valid         <= '0;
          k             <= '0;
        end else begin
          k <= bin_value[AW-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      val_idx <= AW'(value - ValueWidth'(1));
      last_r  <= last_item;
    end
    if (ctrl.load_out) begin
      count       <= bin_cur;
      bin_value   <= inc_out;
      last_result <= (inc_out == BinWidth'(item_count));
    end
  end

  assign in_ready  = ctrl.in_ready;
  assign out_valid = ctrl.out_valid;
  assign overflow  = overflow_seen;

endmodule

// File: rtl/core/lrh_checker.sv
`include "limited_range_histogram_top_assert.svh"

module lrh_checker
  import lrh_pkg::*;
(
  input logic                clk,
  input logic                rst,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input logic [BinWidth-1:0] count,
  input logic [BinWidth-1:0] bin_value,
  input logic                last_result
);

  `LRH_ASSERT_ALWAYS(a_reset_idle, rst |=> in_ready && !out_valid, "not idle after reset")
  `LRH_ASSERT(a_one_side, !(in_ready && out_valid), "input taken during result dump")
  `LRH_ASSERT(a_bin_nonzero, out_valid |-> bin_value != '0, "result for value zero")
  `LRH_ASSERT(a_set_end, out_valid && out_ready && last_result |=> in_ready, "no return to idle")
  `LRH_ASSERT(a_stall_hold, out_valid && !out_ready |=> out_valid && $stable(count), "word lost")

endmodule

bind limited_range_histogram_top lrh_checker u_lrh_checker (.*);

// File: tb/tb_limited_range_histogram_top.sv
module tb_limited_range_histogram_top;
  import lrh_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int MaxItems   = MaxItemsDef;
  localparam int RandWords  = 460;
  localparam int StallLimit = 1000;
  localparam int TailCycles = 16;

  typedef struct packed {
    logic [BinWidth-1:0] cnt;
    logic [BinWidth-1:0] bin;
    logic                last_mark;
    logic                ovf;
  } hist_word_t;

  class histogram_scoreboard;
    logic [BinWidth-1:0] tally[MaxItems];
    int                  n_taken;
    bit                  dropped;
    hist_word_t          pending[$];
    int                  errors;
    int                  sets_done;
    int                  ovf_sets;
    int                  words_taken;
    int                  counts_checked;

    function new();
      foreach (tally[i]) tally[i] = '0;
      n_taken = 0;
      dropped = 0;
      errors = 0;
      sets_done = 0;
      ovf_sets = 0;
      words_taken = 0;
      counts_checked = 0;
    endfunction

    // Bin one accepted word; on the last word queue the counts for 1..N.
    function void note_word(logic [ValueWidth-1:0] v, logic last_mark);
      hist_word_t w;
      words_taken++;
      if (n_taken < MaxItems) begin
        n_taken++;
        if (v >= 1 && v <= MaxItems) tally[v-1] = tally[v-1] + 1'b1;
      end else begin
        dropped = 1;
      end
      if (last_mark) begin
        for (int k = 0; k < n_taken; k++) begin
          w.cnt       = tally[k];
          w.bin       = BinWidth'(k + 1);
          w.last_mark = (k + 1 == n_taken);
          w.ovf       = dropped;
          pending.push_back(w);
        end
        sets_done++;
        if (dropped) ovf_sets++;
        foreach (tally[i]) tally[i] = '0;
        n_taken = 0;
        dropped = 0;
      end
    endfunction

    function void check_word(hist_word_t got);
      hist_word_t want;
      if (pending.size() == 0) begin
        $error("unexpected result word: bin_value %0d count %0d", got.bin, got.cnt);
        errors++;
        return;
      end
      want = pending.pop_front();
      counts_checked++;
      if (got.cnt != want.cnt) begin
        $error("count: expected %0d, got %0d", want.cnt, got.cnt);
        errors++;
      end
      if (got.bin != want.bin) begin
        $error("bin_value: expected %0d, got %0d", want.bin, got.bin);
        errors++;
      end
      if (got.last_mark != want.last_mark) begin
        $error("last_result: expected %0d, got %0d", want.last_mark, got.last_mark);
        errors++;
      end
      if (got.ovf != want.ovf) begin
        $error("overflow: expected %0d, got %0d", want.ovf, got.ovf);
        errors++;
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  in_valid;
  logic                  in_ready;
  logic [ValueWidth-1:0] value;
  logic                  last_item;
  logic                  out_valid;
  logic                  out_ready;
  logic [BinWidth-1:0]   count;
  logic [BinWidth-1:0]   bin_value;
  logic                  last_result;
  logic                  overflow;
  bit                    steady;

  histogram_scoreboard sb = new();

  limited_range_histogram_top #(
    .MaxItems(MaxItems)
  ) u_top (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .value      (value),
    .last_item  (last_item),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .count      (count),
    .bin_value  (bin_value),
    .last_result(last_result),
    .overflow   (overflow)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Receiver stalls at random except during the steady stretch.
  always @(negedge clk) begin
    out_ready = rst ? 1'b0 : (steady || $urandom_range(99) >= 27);
  end

  always @(posedge clk) begin : monitor
    hist_word_t got;
    if (!rst) begin
      if (in_valid && in_ready) sb.note_word(value, last_item);
      if (out_valid && out_ready) begin
        got.cnt       = count;
        got.bin       = bin_value;
        got.last_mark = last_result;
        got.ovf       = overflow;
        sb.check_word(got);
      end
    end
  end

  initial begin : watchdog
    int stalled;
    stalled = 0;
    while (stalled < StallLimit) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) stalled = 0;
      else stalled++;
    end
    $display("watchdog: no word moved for %0d cycles", StallLimit);
    $display("== FAIL ==");
    $finish;
  end

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_word(input logic [ValueWidth-1:0] v, input logic lm);
    while (!steady && $urandom_range(99) < 27) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid  = 1'b1;
    value     = v;
    last_item = lm;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic send_set(input logic [ValueWidth-1:0] vals[$]);
    foreach (vals[i]) send_word(vals[i], i == vals.size() - 1);
  endtask

  // Hold off the sender until every queued count has come back.
  task automatic drain();
    in_valid = 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
  endtask

  initial begin : stimulus
    logic [ValueWidth-1:0] vals[$];
    logic [ValueWidth-1:0] v;
    int size;
    int n;
    int nrand;
    int set_idx;
    int r;

    rst       = 1'b1;
    in_valid  = 1'b0;
    value     = '0;
    last_item = 1'b0;
    steady    = 1'b0;

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Single-word sets: lowest counted value, zero, all ones.
    vals = '{16'd1};
    send_set(vals);
    vals = '{16'd0};
    send_set(vals);
    vals = '{16'hFFFF};
    send_set(vals);
    // Value at the top of the bin range is binned but hidden when N is small.
    vals = '{16'd3, 16'd3, 16'd64, 16'd2};
    send_set(vals);
    vals = '{16'd65, 16'd2};
    send_set(vals);
    vals = '{16'h5555, 16'hAAAA, 16'd1, 16'd1, 16'd5};
    send_set(vals);
    vals = '{16'd4, 16'd4, 16'd4, 16'd4};
    send_set(vals);
    drain();

    nrand   = 0;
    set_idx = 0;
    while (nrand < RandWords) begin
      steady = (set_idx >= 12 && set_idx < 22);
      r = $urandom_range(99);
      if (set_idx == 3) size = MaxItems;
      else if (set_idx == 6 || r < 4) size = $urandom_range(MaxItems + 6, MaxItems + 1);
      else if (r < 16) size = $urandom_range(MaxItems, 13);
      else size = $urandom_range(12, 1);
      n = (size > MaxItems) ? MaxItems : size;
      vals.delete();
      for (int i = 0; i < size; i++) begin
        r = $urandom_range(99);
        if (set_idx == 3) v = ValueWidth'(MaxItems);  // fill one bin to its largest count
        else if (r < 70) v = ValueWidth'($urandom_range(n, 1));
        else if (r < 78) v = '0;
        else if (r < 88) v = ValueWidth'($urandom_range(MaxItems, n));
        else v = ValueWidth'($urandom_range(65535, 0));
        vals.push_back(v);
      end
      send_set(vals);
      nrand += size;
      set_idx++;
      if (set_idx % 9 == 0) drain();
    end
    steady = 1'b0;
    drain();
    repeat (TailCycles) @(negedge clk);

    if (sb.pending.size() != 0) begin
      $error("%0d expected counts never arrived", sb.pending.size());
      sb.errors++;
    end
    $display("Ran %0d histogram sets (%0d of them overflowing), %0d input words.",
             sb.sets_done, sb.ovf_sets, sb.words_taken);
    $display("Checked %0d count words with random stalls on both channels.",
             sb.counts_checked);
    if (sb.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+rtl/core
rtl/core/lrh_pkg.sv
rtl/core/lrh_bin_ram.sv
rtl/core/lrh_seq.sv
rtl/core/limited_range_histogram_top.sv
rtl/core/lrh_checker.sv
tb/tb_limited_range_histogram_top.sv
